// ===== src/ftps_pkg.sv =====
`timescale 1ns / 1ps

package ftps_pkg;

  // fabric arithmetic constants
  localparam int unsigned TOR_SPAN   = 20;  // servers under one tor
  localparam int unsigned SPAN_SCALE = 10;  // aggregation span is 10 * na
  localparam int unsigned SRV_SCALE  = 5;   // servers = 5 * na * ni
  localparam int unsigned TOR_DIV    = 4;   // tors = na * ni / 4
  localparam int unsigned AGG_PAIR   = 2;   // aggregation switches per pod

  // internal widths, set by the 8-bit ni and na registers
  localparam int NN_W    = 16;  // na * ni
  localparam int SPAN_W  = 12;  // 10 * na
  localparam int SRV_W   = 19;  // 5 * na * ni
  localparam int TOR_W   = 14;  // na * ni / 4
  localparam int GRP_W   = 7;   // aggregation pod index
  localparam int BOUND_W = 19;  // role boundaries and range bounds

  typedef enum logic [1:0] {
    ROLE_SERVER,
    ROLE_TOR,
    ROLE_AGG,
    ROLE_CORE
  } role_t;

  typedef struct packed {
    role_t              role;
    logic [BOUND_W-1:0] tor_lo;  // 20 * k for a tor
    logic [BOUND_W-1:0] agg_lo;  // g * span for an aggregation switch
  } class_t;

endpackage

// ===== src/ftps_div_stage.sv =====
`timescale 1ns / 1ps

module ftps_div_stage #(
  parameter int DW    = 32,
  parameter int SW    = 12,
  parameter int QW    = 8,
  parameter int FIRST = 0,
  parameter int NSTEP = 2
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] span_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] span_o
);

  logic [DW-1:0] rem_nxt;
  logic [QW-1:0] quo_nxt;
  logic [DW-1:0] sub_val;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [SW-1:0] span_r;

  // restoring steps, quotient bits shift in msb first
  always_comb begin
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    sub_val = '0;
    for (int j = 0; j < NSTEP; j++) begin
      if (FIRST + j < QW) begin
        sub_val = DW'(span_i) << (QW - 1 - FIRST - j);
        if (rem_nxt >= sub_val) begin
          rem_nxt = rem_nxt - sub_val;
          quo_nxt = {quo_nxt[QW-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    span_r <= span_i;
  end

  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign span_o = span_r;

endmodule

// ===== src/ftps_class.sv =====
`timescale 1ns / 1ps

module ftps_class #(
  parameter int ID_WIDTH = 32
) (
  input  logic                        clk,
  input  logic [ID_WIDTH-1:0]         own_id,
  input  logic [7:0]                  ni,
  input  logic [ftps_pkg::NN_W-1:0]   nn,
  input  logic [ftps_pkg::SPAN_W-1:0] span,
  output ftps_pkg::class_t            cls
);
  import ftps_pkg::*;

  localparam int CW = (ID_WIDTH > BOUND_W) ? ID_WIDTH : BOUND_W;

  logic [CW-1:0] id_ext;

  // stage a
  logic [SRV_W-1:0]  srv_r;
  logic [TOR_W-1:0]  tor_r;
  logic [SPAN_W-1:0] span_a_r;
  // stage b
  logic [BOUND_W-1:0] b1_r;
  logic [BOUND_W-1:0] b2_r;
  logic               lt_srv_b_r;
  logic [TOR_W-1:0]   tor_k_r;
  logic [SPAN_W-1:0]  span_b_r;
  // stage c
  logic               lt_srv_c_r;
  logic               lt_b1_r;
  logic               lt_b2_r;
  logic [7:0]         agg_off_r;
  logic [BOUND_W-1:0] tor_lo_r;
  logic [SPAN_W-1:0]  span_c_r;
  // stage d
  logic [GRP_W-1:0]   grp;
  class_t             cls_r;

  assign id_ext = CW'(own_id);
  assign grp    = GRP_W'(agg_off_r / AGG_PAIR);

  always_ff @(posedge clk) begin
    // server and tor counts
    srv_r    <= SRV_W'(nn * SRV_SCALE);
    tor_r    <= TOR_W'(nn / TOR_DIV);
    span_a_r <= span;

    // role boundaries
    b1_r       <= BOUND_W'(srv_r) + BOUND_W'(tor_r);
    b2_r       <= BOUND_W'(srv_r) + BOUND_W'(tor_r) + BOUND_W'(ni);
    lt_srv_b_r <= id_ext < CW'(srv_r);
    tor_k_r    <= TOR_W'(id_ext - CW'(srv_r));
    span_b_r   <= span_a_r;

    lt_srv_c_r <= lt_srv_b_r;
    lt_b1_r    <= id_ext < CW'(b1_r);
    lt_b2_r    <= id_ext < CW'(b2_r);
    agg_off_r  <= 8'(id_ext - CW'(b1_r));
    tor_lo_r   <= BOUND_W'(tor_k_r * TOR_SPAN);
    span_c_r   <= span_b_r;

    priority if (lt_srv_c_r) begin
      cls_r.role <= ROLE_SERVER;
    end else if (lt_b1_r) begin
      cls_r.role <= ROLE_TOR;
    end else if (lt_b2_r) begin
      cls_r.role <= ROLE_AGG;
    end else begin
      cls_r.role <= ROLE_CORE;
    end
    cls_r.tor_lo <= tor_lo_r;
    cls_r.agg_lo <= BOUND_W'(grp) * BOUND_W'(span_c_r);
  end

  assign cls = cls_r;

endmodule

// ===== src/fat_tree_forward_port_select.sv =====
`timescale 1ns / 1ps

// channel | handshake            | payload
// --------+----------------------+------------------------------------------
// in      | start, busy          | in_src_address, in_dest_address,
//         |                      | in_core_choice, in_down_choice, in_hops_in
// out     | out_valid (strobe)   | out_deliver_local, out_port, out_hops_out
// cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// one header beat per cycle; each beat's result strobes out_valid once the beat
// has passed the capture, prep, quotient, range and select stages
// busy stays low and cfg_ready stays high: every stage advances every cycle
// rst_n (synchronous) clears the valid line and restores the register defaults
// the receiver cannot stall, so no stage ever holds a beat

module fat_tree_forward_port_select #(
  parameter int ID_WIDTH   = 32,
  parameter int PORT_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // header in
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_src_address,
  input  logic [31:0] in_dest_address,
  input  logic [6:0]  in_core_choice,
  input  logic        in_down_choice,
  input  logic [7:0]  in_hops_in,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // decision out
  output logic        out_valid,
  output logic        out_deliver_local,
  output logic [7:0]  out_port,
  output logic [7:0]  out_hops_out
);
  import ftps_pkg::*;

  // register map
  localparam logic [1:0] CFG_OWN_ID = 2'd0;
  localparam logic [1:0] CFG_NI     = 2'd1;
  localparam logic [1:0] CFG_NA     = 2'd2;

  localparam logic [31:0] OWN_ID_RST = 32'd0;
  localparam logic [7:0]  NI_RST     = 8'd4;
  localparam logic [7:0]  NA_RST     = 8'd6;

  // x / 20 as (x * 3277) >> 16, exact for x below 16384
  localparam int unsigned RECIP_20    = 3277;
  localparam int          RECIP_SHIFT = 16;
  localparam int          BYTE_W      = 8;

  // core quotient only matters up to the port limit; its top bit flags overflow
  localparam int QB = (PORT_WIDTH >= 8) ? 7 : PORT_WIDTH - 1;
  localparam int QW = QB + 1;
  localparam int DIV_STAGES = 4;
  localparam int STEP_PER   = (QW + DIV_STAGES - 1) / DIV_STAGES;
  localparam int DW = (ID_WIDTH > SPAN_W + QB) ? ID_WIDTH : SPAN_W + QB;
  localparam int CW = (ID_WIDTH > BOUND_W) ? ID_WIDTH : BOUND_W;
  localparam logic [7:0] PORT_LIMIT =
    (PORT_WIDTH >= 8) ? 8'hFF : 8'((1 << PORT_WIDTH) - 1);

  typedef struct packed {
    logic       eq;        // destination is this switch
    logic       par;       // bit 0 of the folded src ^ dest bytes
    logic [6:0] core;
    logic       down;
    logic [7:0] hops_inc;
  } side_t;

  // configuration registers
  logic [31:0] own_id_r;
  logic [7:0]  ni_r;
  logic [7:0]  na_r;
  logic [ID_WIDTH-1:0] own_id;

  // valid line, one bit per stage up to the range stage, bit 0 is the capture stage
  logic [6:0] vld_r;

  // capture stage
  logic [ID_WIDTH-1:0] src0_r;
  logic [ID_WIDTH-1:0] dest0_r;
  logic [6:0]          core0_r;
  logic                down0_r;
  logic [7:0]          hops0_r;
  logic [ID_WIDTH-1:0] hdr_xor;
  logic                par0;

  // prep stage
  logic [NN_W-1:0]   nn1_r;
  logic [SPAN_W-1:0] span1_r;

  // travelling payload
  side_t               side_r [1:6];
  logic [ID_WIDTH-1:0] dest_r [1:5];

  // core quotient pipeline
  logic [DW-1:0]     div_rem  [0:DIV_STAGES];
  logic [QW-1:0]     div_quo  [0:DIV_STAGES];
  logic [SPAN_W-1:0] div_span [0:DIV_STAGES];

  class_t cls;

  // range stage
  logic [CW-1:0] dest_c;
  logic [CW-1:0] tor_lo_c;
  logic [CW-1:0] agg_lo_c;
  logic [CW-1:0] agg_hi_c;
  logic [CW-1:0] tor_diff;
  role_t         role6_r;
  logic          tor_child6_r;
  logic [4:0]    tor_port6_r;
  logic          agg_child6_r;
  logic [SPAN_W-1:0] agg_rem6_r;
  logic [7:0]    core_port6_r;
  logic [7:0]    agg_up6_r;

  // select stage
  logic [7:0] agg_down;
  logic [7:0] tor_up;
  logic [7:0] port_sel;
  logic [7:0] port_sat;
  logic       out_valid_r;
  logic       deliver_r;
  logic [7:0] port_r;
  logic [7:0] hops_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign own_id    = own_id_r[ID_WIDTH-1:0];

  // the user writes config only while no beat is in flight; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= OWN_ID_RST;
      ni_r     <= NI_RST;
      na_r     <= NA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_ID: own_id_r <= cfg_data;
        CFG_NI:     ni_r     <= cfg_data[7:0];
        CFG_NA:     na_r     <= cfg_data[7:0];
        default:    ;  // index outside the map is dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[5:0], start && !busy};
      out_valid_r <= vld_r[6];
    end
  end

  // header capture, ids cut to ID_WIDTH bits
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      src0_r  <= in_src_address[ID_WIDTH-1:0];
      dest0_r <= in_dest_address[ID_WIDTH-1:0];
      core0_r <= in_core_choice;
      down0_r <= in_down_choice;
      hops0_r <= in_hops_in;
    end
  end

  // xor of all src and dest bytes, only bit 0 of the fold is needed
  assign hdr_xor = src0_r ^ dest0_r;
  always_comb begin
    par0 = 1'b0;
    for (int b = 0; b < ID_WIDTH; b += BYTE_W) begin
      par0 = par0 ^ hdr_xor[b];
    end
  end

  // prep: local match, fabric products
  always_ff @(posedge clk) begin
    side_r[1].eq       <= dest0_r == own_id;
    side_r[1].par      <= par0;
    side_r[1].core     <= core0_r;
    side_r[1].down     <= down0_r;
    side_r[1].hops_inc <= hops0_r + 8'd1;
    dest_r[1]          <= dest0_r;
    nn1_r              <= NN_W'(ni_r) * NN_W'(na_r);
    span1_r            <= SPAN_W'(na_r * SPAN_SCALE);
  end

  always_ff @(posedge clk) begin
    for (int s = 2; s <= 6; s++) begin
      side_r[s] <= side_r[s-1];
    end
    for (int s = 2; s <= 5; s++) begin
      dest_r[s] <= dest_r[s-1];
    end
  end

  // role and range bounds of this switch
  ftps_class #(
    .ID_WIDTH (ID_WIDTH)
  ) u_class (
    .clk    (clk),
    .own_id (own_id),
    .ni     (ni_r),
    .nn     (nn1_r),
    .span   (span1_r),
    .cls    (cls)
  );

  // dest / span for the core switch, a few restoring steps per stage
  assign div_rem[0]  = DW'(dest_r[1]);
  assign div_quo[0]  = '0;
  assign div_span[0] = span1_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    ftps_div_stage #(
      .DW    (DW),
      .SW    (SPAN_W),
      .QW    (QW),
      .FIRST (g * STEP_PER),
      .NSTEP (STEP_PER)
    ) u_div (
      .clk    (clk),
      .rem_i  (div_rem[g]),
      .quo_i  (div_quo[g]),
      .span_i (div_span[g]),
      .rem_o  (div_rem[g+1]),
      .quo_o  (div_quo[g+1]),
      .span_o (div_span[g+1])
    );
  end

  // range tests against dest
  assign dest_c   = CW'(dest_r[5]);
  assign tor_lo_c = CW'(cls.tor_lo);
  assign agg_lo_c = CW'(cls.agg_lo);
  assign agg_hi_c = CW'(cls.agg_lo) + CW'(div_span[DIV_STAGES]);
  assign tor_diff = dest_c - tor_lo_c;

  always_ff @(posedge clk) begin
    role6_r      <= cls.role;
    // under a tor: dest within its block of 20, port is the offset
    tor_child6_r <= (dest_c >= tor_lo_c) && (tor_diff < CW'(TOR_SPAN));
    tor_port6_r  <= tor_diff[4:0];
    // under an aggregation pod; an empty span never matches
    agg_child6_r <= (dest_c >= agg_lo_c) && (dest_c < agg_hi_c);
    agg_rem6_r   <= SPAN_W'(dest_c - agg_lo_c);
    // core: overflowed quotient saturates, else 2q + down
    core_port6_r <= div_quo[DIV_STAGES][QW-1] ? PORT_LIMIT :
                    8'({div_quo[DIV_STAGES][QW-2:0], side_r[5].down});
    agg_up6_r    <= 8'(na_r / AGG_PAIR) + 8'(side_r[5].core);
  end

  assign agg_down = 8'((agg_rem6_r * RECIP_20) >> RECIP_SHIFT);
  assign tor_up   = 8'(TOR_SPAN) + 8'(side_r[6].par);

  always_comb begin
    unique case (role6_r)
      ROLE_SERVER: port_sel = tor_up;
      ROLE_TOR:    port_sel = tor_child6_r ? 8'(tor_port6_r) : tor_up;
      ROLE_AGG:    port_sel = agg_child6_r ? agg_down : agg_up6_r;
      ROLE_CORE:   port_sel = core_port6_r;
    endcase
  end

  assign port_sat = (port_sel > PORT_LIMIT) ? PORT_LIMIT : port_sel;

  // local delivery clears port and hop count
  always_ff @(posedge clk) begin
    deliver_r <= side_r[6].eq;
    port_r    <= side_r[6].eq ? 8'd0 : port_sat;
    hops_r    <= side_r[6].eq ? 8'd0 : side_r[6].hops_inc;
  end

  assign out_valid         = out_valid_r;
  assign out_deliver_local = deliver_r;
  assign out_port          = port_r;
  assign out_hops_out      = hops_r;

endmodule

// ===== tb/ftps_tb_pkg.sv =====
`timescale 1ns / 1ps

package ftps_tb_pkg;

  // configuration register map
  typedef enum logic [1:0] {
    REG_OWN_ID       = 2'd0,
    REG_INTERMEDIATE = 2'd1,
    REG_AGGREGATE    = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

endpackage

// ===== tb/ftps_decision_checker.sv =====
`timescale 1ns / 1ps

module ftps_decision_checker
  import ftps_pkg::*;
  import ftps_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_src_address,
  input  logic [31:0] in_dest_address,
  input  logic [6:0]  in_core_choice,
  input  logic        in_down_choice,
  input  logic [7:0]  in_hops_in,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_deliver_local,
  input  logic [7:0]  out_port,
  input  logic [7:0]  out_hops_out,
  output int          mismatch_count,
  output int          decisions_due
);

  typedef struct packed {
    logic       deliver_local;
    logic [7:0] port;
    logic [7:0] hops;
  } decision_t;

  localparam logic [63:0] PORT_MAX  = 64'd255;
  localparam logic [63:0] NO_SPAN_Q = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam int          PRINT_CAP = 40;

  logic [31:0] own_id = 32'd0;
  logic [7:0]  ni_reg = 8'd4;
  logic [7:0]  na_reg = 8'd6;
  decision_t   awaited_decisions[$];
  int          errors  = 0;
  int          printed = 0;

  function automatic decision_t predict_decision(input logic [31:0] src, dest,
                                                 input logic [6:0] core,
                                                 input logic down,
                                                 input logic [7:0] hops);
    logic [63:0] id, dst, ni, na, srv, tor, agg, span, lo, port;
    logic [31:0] mix;
    logic [7:0]  fold;
    logic        below;
    role_t       role;
    decision_t   d;
    id   = 64'(own_id);
    dst  = 64'(dest);
    ni   = 64'(ni_reg);
    na   = 64'(na_reg);
    if (dest == own_id) begin
      d = '{deliver_local: 1'b1, port: 8'd0, hops: 8'd0};
      return d;
    end
    srv  = SRV_SCALE * na * ni;
    tor  = (na * ni) / TOR_DIV;
    agg  = ni;
    span = SPAN_SCALE * na;
    if (id < srv) role = ROLE_SERVER;
    else if (id < srv + tor) role = ROLE_TOR;
    else if (id < srv + tor + agg) role = ROLE_AGG;
    else role = ROLE_CORE;
    case (role)
      ROLE_SERVER: below = 1'b0;
      ROLE_TOR: begin
        lo    = TOR_SPAN * (id - srv);
        below = (dst >= lo) && (dst < lo + TOR_SPAN);
      end
      ROLE_AGG: begin
        lo    = ((id - srv - tor) / AGG_PAIR) * span;
        below = (dst >= lo) && (dst < lo + span);
      end
      default: below = 1'b1;
    endcase
    mix  = src ^ dest;
    fold = mix[7:0] ^ mix[15:8] ^ mix[23:16] ^ mix[31:24];
    port = 64'd0;
    if (below) begin
      case (role)
        ROLE_TOR: port = dst % TOR_SPAN;
        ROLE_AGG: port = ((span != 0) ? dst % span : dst) / TOR_SPAN;
        default:  port = ((span != 0) ? dst / span : NO_SPAN_Q) * 2 + 64'(down);
      endcase
    end else begin
      case (role)
        ROLE_SERVER, ROLE_TOR: port = TOR_SPAN + 64'(fold[0]);
        ROLE_AGG:              port = na / AGG_PAIR + 64'(core);
        default:               port = 64'd0;
      endcase
    end
    d.deliver_local = 1'b0;
    d.port          = (port > PORT_MAX) ? 8'hFF : port[7:0];
    d.hops          = hops + 8'd1;
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (printed < PRINT_CAP) begin
      printed++;
      $display("%0t ns: decision mismatch: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (!rst_n) begin
      own_id = 32'd0;
      ni_reg = 8'd4;
      na_reg = 8'd6;
      awaited_decisions.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_OWN_ID:       own_id = cfg_data;
          REG_INTERMEDIATE: ni_reg = cfg_data[7:0];
          REG_AGGREGATE:    na_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (awaited_decisions.size() == 0) begin
          report_mismatch("result beat with no header outstanding");
        end else begin
          want = awaited_decisions.pop_front();
          if (out_deliver_local !== want.deliver_local)
            report_mismatch($sformatf("deliver_local %0b, predicted %0b",
                                      out_deliver_local, want.deliver_local));
          if (out_port !== want.port)
            report_mismatch($sformatf("out_port %0d, predicted %0d", out_port, want.port));
          if (out_hops_out !== want.hops)
            report_mismatch($sformatf("hops_out %0d, predicted %0d", out_hops_out, want.hops));
        end
      end
      if (start && !busy)
        awaited_decisions.push_back(predict_decision(in_src_address, in_dest_address,
                                                     in_core_choice, in_down_choice,
                                                     in_hops_in));
    end
    mismatch_count <= errors;
    decisions_due  <= awaited_decisions.size();
  end

endmodule

// ===== tb/fat_tree_forward_port_select_test.sv =====
`timescale 1ns / 1ps

module fat_tree_forward_port_select_test;
  import ftps_pkg::*;
  import ftps_tb_pkg::*;

  // generous bound for ~1700 headers and their sender gaps
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int          PHASES      = 24;
  localparam int          PHASE_BEATS = 70;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        start             = 1'b0;
  logic        busy;
  logic [31:0] in_src_address    = 32'd0;
  logic [31:0] in_dest_address   = 32'd0;
  logic [6:0]  in_core_choice    = 7'd0;
  logic        in_down_choice    = 1'b0;
  logic [7:0]  in_hops_in        = 8'd0;
  logic        cfg_valid         = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index         = REG_OWN_ID;
  logic [31:0] cfg_data          = 32'd0;
  logic        out_valid;
  logic        out_deliver_local;
  logic [7:0]  out_port;
  logic [7:0]  out_hops_out;

  int          mismatch_count;
  int          decisions_due;
  int unsigned cycle_count = 0;

  // current own id, mirrored here only to aim the destinations
  logic [31:0] cur_own;
  logic [63:0] cur_lo, cur_hi;   // range of node ids below this switch
  bit          burst;            // no sender gaps while set
  logic [7:0]  phase_ni, phase_na;

  fat_tree_forward_port_select u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_src_address    (in_src_address),
    .in_dest_address   (in_dest_address),
    .in_core_choice    (in_core_choice),
    .in_down_choice    (in_down_choice),
    .in_hops_in        (in_hops_in),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_deliver_local (out_deliver_local),
    .out_port          (out_port),
    .out_hops_out      (out_hops_out)
  );

  ftps_decision_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_src_address    (in_src_address),
    .in_dest_address   (in_dest_address),
    .in_core_choice    (in_core_choice),
    .in_down_choice    (in_down_choice),
    .in_hops_in        (in_hops_in),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_deliver_local (out_deliver_local),
    .out_port          (out_port),
    .out_hops_out      (out_hops_out),
    .mismatch_count    (mismatch_count),
    .decisions_due     (decisions_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[fat_tree_forward_port_select] ERROR");
      $finish;
    end
  end

  // one header beat; start stays high across back-to-back beats
  task automatic send_header(input logic [31:0] src, dest, input logic [6:0] core,
                             input logic down, input logic [7:0] hops);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_src_address  <= src;
    in_dest_address <= dest;
    in_core_choice  <= core;
    in_down_choice  <= down;
    in_hops_in      <= hops;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // hold the sender off until every outstanding decision has come back
  task automatic drain_decisions();
    start <= 1'b0;
    do @(posedge clk); while (decisions_due != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // registers change only with the pipeline empty; write order is shuffled and
  // the upper bits of the 8-bit registers sometimes carry junk
  task automatic configure(input logic [31:0] own, input logic [7:0] ni, na,
                           input bit poke_spare);
    int          rot;
    logic [31:0] junk;
    drain_decisions();
    rot = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      case ((rot + i) % 3)
        0:       write_reg(REG_OWN_ID, own);
        1:       write_reg(REG_INTERMEDIATE, {junk[31:8], ni});
        default: write_reg(REG_AGGREGATE, {junk[31:8], na});
      endcase
    end
    // the unmapped index must not disturb anything
    if (poke_spare || $urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    cur_own = own;
  endtask

  // place this switch in the wanted tier of the fabric, falling back to core
  // when that tier is empty for these sizes
  task automatic set_role(input role_t want, input logic [7:0] ni, na, input bit poke_spare);
    logic [63:0] srv, tor, agg, span, idx, lo, hi;
    logic [31:0] own;
    role_t       role;
    srv  = SRV_SCALE * 64'(na) * 64'(ni);
    tor  = (64'(na) * 64'(ni)) / TOR_DIV;
    agg  = 64'(ni);
    span = SPAN_SCALE * 64'(na);
    role = want;
    if (role == ROLE_SERVER && srv == 0) role = ROLE_CORE;
    if (role == ROLE_TOR && tor == 0) role = ROLE_CORE;
    if (role == ROLE_AGG && agg == 0) role = ROLE_CORE;
    case (role)
      ROLE_SERVER: begin
        idx = ($urandom_range(0, 2) == 0) ? srv - 1 : 64'($urandom) % srv;
        own = 32'(idx);
        lo  = 64'd0;
        hi  = srv;
      end
      ROLE_TOR: begin
        case ($urandom_range(0, 2))
          0:       idx = 64'd0;
          1:       idx = tor - 1;
          default: idx = 64'($urandom) % tor;
        endcase
        own = 32'(srv + idx);
        lo  = TOR_SPAN * idx;
        hi  = lo + TOR_SPAN;
      end
      ROLE_AGG: begin
        case ($urandom_range(0, 2))
          0:       idx = 64'd0;
          1:       idx = agg - 1;
          default: idx = 64'($urandom) % agg;
        endcase
        own = 32'(srv + tor + idx);
        lo  = (idx / AGG_PAIR) * span;
        hi  = lo + span;
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       own = 32'(srv + tor + agg);
          1:       own = 32'hFFFF_FFFF;
          default: own = 32'(srv + tor + agg + $urandom_range(0, 1000));
        endcase
        // core ports stay unsaturated below about 128 spans
        lo = 64'd0;
        hi = (span == 0) ? 64'd4096 : span * 130;
      end
    endcase
    configure(own, ni, na, poke_spare);
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // mostly destinations that land below this switch or on it, some noise
  function automatic logic [31:0] pick_dest();
    logic [63:0] width;
    width = cur_hi - cur_lo;
    case ($urandom_range(0, 11))
      0: return cur_own;
      1, 2, 3, 4, 5: return (width != 0) ? 32'(cur_lo + 64'($urandom) % width) : $urandom;
      6: begin
        case ($urandom_range(0, 3))
          0:       return 32'(cur_lo - 1);
          1:       return 32'(cur_lo);
          2:       return 32'(cur_hi - 1);
          default: return 32'(cur_hi);
        endcase
      end
      7:  return $urandom;
      8:  return $urandom_range(0, 4095);
      9:  return ($urandom_range(0, 1) != 0) ? cur_own + 32'd1 : cur_own - 32'd1;
      10: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [7:0] pick_hops();
    case ($urandom_range(0, 7))
      0:       return 8'hFF;
      1:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    // mirror of the reset defaults: own id 0, ni 4, na 6, a server position
    cur_own = 32'd0;
    cur_lo  = 64'd0;
    cur_hi  = 64'd120;
    burst   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: server position under reset defaults
    send_header(32'h0000_0000, 32'h0000_0000, 7'd0,   1'b0, 8'h00);  // local delivery
    send_header(32'hFFFF_FFFF, 32'h0000_0000, 7'd127, 1'b1, 8'hFF);  // local, hops ignored
    send_header(32'h0000_0000, 32'h0000_0001, 7'd0,   1'b0, 8'hFF);  // odd parity, hops wrap
    send_header(32'h0000_0100, 32'h0000_0001, 7'd5,   1'b1, 8'h10);  // bytes cancel
    send_header(32'h0000_0000, 32'hFFFF_FFFF, 7'd127, 1'b1, 8'hFE);  // all-ones destination

    // tor 0: servers 0..19 below it
    configure(32'd120, 8'd4, 8'd6, 1'b0);
    send_header(32'h1234_5678, 32'd0,   7'd0,   1'b0, 8'd1);
    send_header(32'h1234_5678, 32'd19,  7'd0,   1'b1, 8'd2);
    send_header(32'h0000_0015, 32'd20,  7'd9,   1'b0, 8'd3);   // just past the tor range
    send_header(32'h0000_0000, 32'd120, 7'd9,   1'b0, 8'd4);   // own id

    // aggregation 0: pod 0 covers 0..59
    configure(32'd126, 8'd4, 8'd6, 1'b0);
    send_header(32'hA5A5_A5A5, 32'd59,  7'd0,   1'b0, 8'd5);
    send_header(32'hA5A5_A5A5, 32'd60,  7'd127, 1'b1, 8'd6);   // up by core index
    send_header(32'hA5A5_A5A5, 32'd126, 7'd1,   1'b0, 8'd7);

    // core at the top id: down by pod, saturating past port 255
    configure(32'hFFFF_FFFF, 8'd4, 8'd6, 1'b1);
    send_header(32'd0, 32'd0,          7'd0, 1'b0, 8'd8);
    send_header(32'd0, 32'd59,         7'd0, 1'b1, 8'd9);
    send_header(32'd0, 32'd7620,       7'd0, 1'b1, 8'd10);   // exactly port 255
    send_header(32'd0, 32'd7680,       7'd0, 1'b0, 8'd11);   // one past, saturates
    send_header(32'd0, 32'hFFFF_FFFE,  7'd0, 1'b1, 8'd12);
    send_header(32'd0, 32'hFFFF_FFFF,  7'd0, 1'b1, 8'd13);   // own id

    // zero na: empty aggregation range, core quotient saturates
    configure(32'd0, 8'd4, 8'd0, 1'b0);
    send_header(32'd0, 32'd5, 7'd7, 1'b0, 8'd14);
    configure(32'd4, 8'd4, 8'd0, 1'b0);
    send_header(32'd0, 32'd1, 7'd7, 1'b1, 8'd15);

    // widest fabric
    configure(32'hFFFF_FFFF, 8'd255, 8'd255, 1'b0);
    send_header(32'hFFFF_FFFF, 32'd0,         7'd127, 1'b1, 8'hFF);
    send_header(32'h0000_0000, 32'hFFFF_0000, 7'd0,   1'b0, 8'h00);

    // random phases: chosen sizes, mostly extremes, first, then drawn; tiers rotate
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin phase_ni = 8'd1;   phase_na = 8'd2;   end
        1: begin phase_ni = 8'd255; phase_na = 8'd255; end
        2: begin phase_ni = 8'd4;   phase_na = 8'd6;   end
        3: begin phase_ni = 8'd1;   phase_na = 8'd255; end
        4: begin phase_ni = 8'd255; phase_na = 8'd2;   end
        5: begin phase_ni = 8'd0;   phase_na = 8'd5;   end
        6: begin phase_ni = 8'd8;   phase_na = 8'd0;   end
        7: begin phase_ni = 8'd3;   phase_na = 8'd0;   end
        default: begin
          phase_ni = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                 : 8'($urandom_range(1, 16));
          phase_na = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255))
                                                 : 8'($urandom_range(2, 16));
        end
      endcase
      set_role(role_t'(phase % 4), phase_ni, phase_na, phase == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // stretches of back-to-back beats come and go
        if (n % 16 == 0) burst = ($urandom_range(0, 3) == 0);
        if ((phase == 3 && n == 35) || $urandom_range(0, 149) == 0) drain_decisions();
        send_header($urandom, pick_dest(), 7'($urandom), 1'($urandom), pick_hops());
      end
    end

    drain_decisions();
    // a few more cycles for any stray result beat
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[fat_tree_forward_port_select] OK");
    end else begin
      $display("[fat_tree_forward_port_select] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ftps_pkg.sv
src/ftps_div_stage.sv
src/ftps_class.sv
src/fat_tree_forward_port_select.sv
tb/ftps_tb_pkg.sv
tb/ftps_decision_checker.sv
tb/fat_tree_forward_port_select_test.sv
